[design/sidi_pkg.sv]
`default_nettype none

package sidi_pkg;

	// Field widths
	localparam int ValueWidth = 32;
	localparam int CharWidth  = 6;

	// Decimal digits needed for a 32-bit magnitude
	localparam int NumDigits  = 10;
	localparam int DigitWidth = 4;
	localparam int CountWidth = $clog2(NumDigits + 1);
	localparam int ShiftWidth = $clog2(ValueWidth);

	// ASCII codes, truncated to the character field
	localparam logic [CharWidth-1:0] AsciiZero  = CharWidth'(48);
	localparam logic [CharWidth-1:0] AsciiMinus = CharWidth'(45);

	typedef logic [DigitWidth-1:0] digit_t;
	typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_t;

endpackage

`default_nettype wire

[design/sidi_bcd.sv]
`default_nettype none

// Bit-serial binary to BCD conversion (shift and add-3).
// One magnitude bit enters the BCD register per cycle.
module sidi_bcd (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire logic [sidi_pkg::ValueWidth-1:0] mag,
	output logic                                 done,
	output sidi_pkg::bcd_t                       bcd
);
	import sidi_pkg::*;

	logic [ValueWidth-1:0] bin_q;
	bcd_t                  bcd_q;
	bcd_t                  adj;
	logic [ShiftWidth-1:0] cnt_q;
	logic                  run_q;
	logic                  done_q;

	// Add 3 to every digit that is 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= DigitWidth'(5)) ? bcd_q[i] + DigitWidth'(3) : bcd_q[i];
		end
	end

	// Shift control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ShiftWidth'(ValueWidth - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Binary and BCD shift registers
	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q    <= {bin_q[ValueWidth-2:0], 1'b0};
			bcd_q[0] <= {adj[0][DigitWidth-2:0], bin_q[ValueWidth-1]};
			for (int i = 1; i < NumDigits; i++) begin
				bcd_q[i] <= {adj[i][DigitWidth-2:0], adj[i-1][DigitWidth-1]};
			end
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

[design/signed_int_to_decimal_ascii_top.sv]
`default_nettype none

// Signed 32-bit integer to decimal ASCII. An item is taken when start is high and busy is low;
// its magnitude is loaded into a bit-serial BCD converter, one bit per cycle, and the digit
// string is sized when the converter is done. The characters then leave one per cycle, '-'
// first for a negative value, most significant digit first, no leading zeros, with last_char
// on the final one. An item yields 1 to 11 characters and keeps busy high until its final
// character is shown, so no new item is taken before then.
// Each character is shown with valid for exactly one cycle and must be taken then: the
// receiver cannot stall the block.
module signed_int_to_decimal_ascii_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [sidi_pkg::ValueWidth-1:0] value,
	output logic                                        busy,
	output logic                                        valid,
	output logic [sidi_pkg::CharWidth-1:0]              character,
	output logic                                        last_char
);
	import sidi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic                  accept;
	logic [ValueWidth-1:0] mag;
	logic                  conv_done;
	bcd_t                  bcd;
	logic                  sign_q;
	logic [CountWidth-1:0] rem_q;
	logic [CountWidth-1:0] ndig;
	digit_t                cur_digit;
	logic                  valid_q;
	logic [CharWidth-1:0]  char_q;
	logic                  last_q;

	assign accept = start && (state_q == ST_IDLE);
	assign mag    = ValueWidth'(0) - $unsigned(value);

	sidi_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.mag    (value[ValueWidth-1] ? mag : $unsigned(value)),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// Significant digit count, at least one for zero
	always_comb begin
		ndig = CountWidth'(1);
		for (int i = 1; i < NumDigits; i++) begin
			if (bcd[i] != '0) ndig = CountWidth'(i + 1);
		end
	end

	assign cur_digit = bcd[rem_q - 1'b1];

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sign_q  <= 1'b0;
			rem_q   <= '0;
			valid_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sign_q  <= value[ValueWidth-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						rem_q   <= ndig;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					valid_q <= 1'b1;
					if (sign_q) begin
						sign_q <= 1'b0;
						char_q <= AsciiMinus;
						last_q <= 1'b0;
					end else begin
						char_q <= AsciiZero + CharWidth'(cur_digit);
						last_q <= (rem_q == CountWidth'(1));
						rem_q  <= rem_q - 1'b1;
						if (rem_q == CountWidth'(1)) state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign valid     = valid_q;
	assign character = char_q;
	assign last_char = last_q;

	// The final character of a number frees the block in the same cycle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last_char |-> !busy) else $error("busy after final character");

	// Characters of one number leave back to back
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_char |=> valid) else $error("gap inside a number");

	// A minus sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (character == AsciiMinus) |-> !last_char) else $error("lone minus sign");

	// A transfer in starts the conversion
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !valid) else $error("item not taken");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import sidi_pkg::*;

	// One character of decimal text as it leaves the block
	typedef struct packed {
		logic [CharWidth-1:0] code;
		logic                 last;
	} text_char_t;

	// Directed stimulus: an empty string means the expected text comes from the predictor
	typedef struct {
		logic signed [ValueWidth-1:0] num;
		string                        text;
	} directed_row_t;

	localparam int NumDirected  = 20;
	localparam int RandomCount  = 400;
	localparam int DrainCycles  = 60;
	localparam int ReportLimit  = 10;

	logic                         clk    = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start  = 1'b0;
	logic signed [ValueWidth-1:0] value  = '0;
	logic                         busy;
	logic                         valid;
	logic [CharWidth-1:0]         character;
	logic                         last_char;

	text_char_t    pending_chars[$];
	directed_row_t directed_rows[NumDirected];
	int            numbers_sent  = 0;
	int            chars_checked = 0;
	int            mismatches    = 0;

	signed_int_to_decimal_ascii_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.valid     (valid),
		.character (character),
		.last_char (last_char)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Failure bookkeeping: first few are printed, the rest only counted
	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= ReportLimit)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Decimal text of a signed number, sign first, digits from the unsigned magnitude
	function automatic void predict_text(input logic signed [ValueWidth-1:0] num);
		logic [ValueWidth-1:0] magnitude;
		digit_t                digits[NumDigits];
		int                    n;
		magnitude = num[ValueWidth-1] ? (~num + 1'b1) : num;
		n = 0;
		do begin
			digits[n] = digit_t'(magnitude % 10);
			magnitude = magnitude / 10;
			n++;
		end while (magnitude != 0 && n < NumDigits);
		if (num[ValueWidth-1])
			pending_chars.push_back(text_char_t'{code: AsciiMinus, last: 1'b0});
		for (int i = n - 1; i >= 0; i--)
			pending_chars.push_back(text_char_t'{code: AsciiZero + CharWidth'(digits[i]),
				last: (i == 0)});
	endfunction

	// Expected text typed in directly
	function automatic void expect_text(input string text);
		for (int i = 0; i < text.len(); i++)
			pending_chars.push_back(text_char_t'{code: CharWidth'(text[i]),
				last: (i == text.len() - 1)});
	endfunction

	// One number transfer; hold keeps start high for a back-to-back number
	task automatic send_number(input logic signed [ValueWidth-1:0] num, input string text,
		input bit hold);
		start <= 1'b1;
		value <= num;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (text.len() != 0)
			expect_text(text);
		else
			predict_text(num);
		numbers_sent++;
		if (!hold)
			start <= 1'b0;
	endtask

	// Wait until every expected character has come out
	task automatic drain;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	// Random number, mostly with a random digit count so short and long texts both occur
	function automatic logic signed [ValueWidth-1:0] random_number();
		longint unsigned lo;
		longint unsigned hi;
		int              ndig;
		logic [ValueWidth-1:0] mag;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		ndig = $urandom_range(1, NumDigits);
		lo = (ndig == 1) ? 0 : 10 ** (ndig - 1);
		hi = (ndig == NumDigits) ? 64'd2147483648 : 10 ** ndig - 1;
		mag = $urandom_range(int'(hi), int'(lo));
		if ($urandom_range(0, 1) == 1 || mag == 32'h80000000)
			return ~mag + 1'b1;
		return mag;
	endfunction

	// Result checker: the receiver takes every character on its strobe
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && valid) begin
			if (pending_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected character %0d ('%c') last_char %0b",
					character, 8'(character), last_char));
			end else begin
				want = pending_chars.pop_front();
				if (character !== want.code || last_char !== want.last)
					note_mismatch($sformatf(
						"character exp %0d got %0d, last_char exp %0b got %0b",
						want.code, character, want.last, last_char));
				chars_checked++;
			end
		end
	end

	// Stimulus
	initial begin
		int remaining;
		int burst;
		int gap;
		bit last_in_burst;
		directed_rows = '{
			'{32'sd0,           "0"},
			'{32'sd1,           "1"},
			'{-32'sd1,          "-1"},
			'{32'sd9,           "9"},
			'{-32'sd9,          "-9"},
			'{32'sd10,          "10"},
			'{-32'sd10,         "-10"},
			'{32'sd100,         "100"},
			'{32'sd1000000000,  "1000000000"},
			'{32'sd2147483647,  "2147483647"},
			'{32'h80000000,     "-2147483648"},
			'{32'h80000001,     "-2147483647"},
			'{32'sd999999999,   "999999999"},
			'{-32'sd999999999,  "-999999999"},
			'{32'h55555555,     ""},
			'{32'hAAAAAAAA,     ""},
			'{32'h7FFF0000,     ""},
			'{32'h8000FFFF,     ""},
			'{32'sd1234567890,  ""},
			'{-32'sd1000000001, ""}
		};

		// Hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed numbers: extremes, zero, sign and digit-count boundaries
		for (int r = 0; r < NumDirected; r++) begin
			gap = $urandom_range(0, 2);
			send_number(directed_rows[r].num, directed_rows[r].text, gap == 0);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b0;
		drain();
		@(posedge clk);

		// Random numbers in bursts with random gaps; a full pause half way through
		remaining = RandomCount;
		while (remaining > 0) begin
			burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
			for (int k = 0; k < burst && remaining > 0; k++) begin
				last_in_burst = (k == burst - 1) || remaining == 1
					|| remaining == RandomCount / 2 + 1;
				send_number(random_number(), "", !last_in_burst);
				remaining--;
				if (last_in_burst) begin
					// noise on the data lines while start is low
					value <= $urandom;
					if (remaining == RandomCount / 2)
						drain();
					else begin
						gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
							: $urandom_range(1, 30);
						repeat (gap) @(posedge clk);
					end
				end
			end
		end

		// Let the last text come out, then watch for stray characters
		drain();
		repeat (DrainCycles) @(posedge clk);
		if (pending_chars.size() != 0)
			note_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

		$display("Converted %0d numbers (%0d directed, %0d random), %0d characters compared.",
			numbers_sent, NumDirected, numbers_sent - NumDirected, chars_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
design/sidi_pkg.sv
design/sidi_bcd.sv
design/signed_int_to_decimal_ascii_top.sv
bench/testbench.sv
